### src/crt_pkg.sv
// Shared types, constants and helpers of the trail Catmull-Rom tessellator.
package crt_pkg;

    localparam int Q_ONE = 32768;
    localparam int WIN   = 4;
    localparam int NW    = 48;

    localparam logic [2:0] REG_LINE_WIDTH      = 3'd0;
    localparam logic [2:0] REG_HIGHLIGHT_WIDTH = 3'd1;
    localparam logic [2:0] REG_BASE_COLOR      = 3'd2;
    localparam logic [2:0] REG_FULL_TEXTURE    = 3'd3;
    localparam logic [2:0] REG_TEX_U_EDGE_A    = 3'd4;
    localparam logic [2:0] REG_TEX_U_EDGE_B    = 3'd5;
    localparam logic [2:0] REG_TEX_V_EDGE_A    = 3'd6;
    localparam logic [2:0] REG_TEX_V_EDGE_B    = 3'd7;

    typedef struct packed {
        logic [15:0] line_width;
        logic [15:0] highlight_width;
        logic [31:0] base_color;
        logic        full_texture;
        logic [15:0] tex_u_edge_a;
        logic [15:0] tex_u_edge_b;
        logic [15:0] tex_v_edge_a;
        logic [15:0] tex_v_edge_b;
    } cfg_t;

    typedef struct packed {
        logic [2:0][31:0] ea;
        logic [2:0][31:0] eb;
        logic [1:0][15:0] uva;
        logic [1:0][15:0] uvb;
        logic [31:0]      col;
    } seg_rec_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CALC,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_COEF,
        B_MUL,
        B_SUM,
        B_DIV,
        B_OUT
    } back_state_t;

    function automatic logic [31:0] sat_s32(input logic signed [NW-1:0] v);
        logic [31:0] r;
        if (v > 48'sh0000_7FFF_FFFF)
            r = 32'h7FFF_FFFF;
        else if (v < -48'sh0000_8000_0000)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [15:0] sat_u16(input logic signed [NW-1:0] v);
        logic [15:0] r;
        if (v < 48'sd0)
            r = 16'h0000;
        else if (v > 48'sd65535)
            r = 16'hFFFF;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

### src/crt_seg_if.sv
// Segment input channel.
interface crt_seg_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic signed [31:0] base_z;
    logic signed [31:0] tip_x;
    logic signed [31:0] tip_y;
    logic signed [31:0] tip_z;
    logic               visible;

    modport source (output valid, base_x, base_y, base_z, tip_x, tip_y, tip_z, visible,
                    input ready);
    modport sink (input valid, base_x, base_y, base_z, tip_x, tip_y, tip_z, visible,
                  output ready);
endinterface

### src/crt_vtx_if.sv
// Vertex output channel.
interface crt_vtx_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [31:0]        vertex_color;
    logic               edge_res;
    logic [1:0]         substep;
    logic               last;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, vertex_color,
                    edge_res, substep, last, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, vertex_color,
                  edge_res, substep, last, output ready);
endinterface

### src/crt_front.sv
// Front end: accepts segments, derives edge points, color and texture coordinates.
module crt_front #(
    parameter int TRAIL_SEGMENTS = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    crt_seg_if.sink           seg,
    input  crt_pkg::cfg_t     cfg,
    output crt_pkg::seg_rec_t rec,
    output logic              rec_valid,
    input  logic              rec_ready
);
    import crt_pkg::*;

    localparam int SW = $clog2(TRAIL_SEGMENTS);

    front_state_t       state_reg, state_next;
    logic [SW-1:0]      step_reg, step_next;
    logic [1:0]         k_reg, k_next;
    logic               ph_reg, ph_next;
    logic signed [31:0] base_reg [3];
    logic signed [31:0] tip_reg [3];
    logic [31:0]        ea_reg [3];
    logic [31:0]        eb_reg [3];
    logic [1:0][15:0]   uva_reg;
    logic [1:0][15:0]   uvb_reg;
    logic [31:0]        col_reg;

    logic [15:0]        u_tab [TRAIL_SEGMENTS];
    logic [15:0]        hw_c, lw_c;
    logic [16:0]        wa, wb, w;
    logic signed [31:0] p1, p2;
    logic signed [49:0] diff, prod, rnd;
    logic signed [NW-1:0] sum;
    logic [31:0]        res;
    logic               accept;

    for (genvar i = 0; i < TRAIL_SEGMENTS; i++) begin : g_utab
        localparam logic [15:0] U_VAL = 16'(((2 * i * Q_ONE) + (TRAIL_SEGMENTS - 1))
                                            / (2 * (TRAIL_SEGMENTS - 1)));
        assign u_tab[i] = U_VAL;
    end

    assign hw_c = (cfg.highlight_width > 16'(Q_ONE)) ? 16'(Q_ONE) : cfg.highlight_width;
    assign lw_c = (cfg.line_width > 16'(Q_ONE)) ? 16'(Q_ONE) : cfg.line_width;
    assign wa   = 17'(Q_ONE) - {1'b0, hw_c};
    assign wb   = 17'(Q_ONE) - {1'b0, lw_c};

    assign p1   = base_reg[k_reg];
    assign p2   = ph_reg ? $signed(ea_reg[k_reg]) : tip_reg[k_reg];
    assign w    = ph_reg ? wb : wa;
    assign diff = 50'(p2) - 50'(p1);
    assign prod = diff * $signed({33'b0, w});
    assign rnd  = (prod + 50'sd16384) >>> 15;
    assign sum  = NW'(rnd) + NW'(p1);
    assign res  = sat_s32(sum);

    assign accept    = seg.valid && seg.ready;
    assign seg.ready = (state_reg == F_IDLE);
    assign rec_valid = (state_reg == F_PUSH);

    always_comb
    begin
        rec.ea  = {ea_reg[2], ea_reg[1], ea_reg[0]};
        rec.eb  = {eb_reg[2], eb_reg[1], eb_reg[0]};
        rec.uva = uva_reg;
        rec.uvb = uvb_reg;
        rec.col = col_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        k_next     = k_reg;
        ph_next    = ph_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    step_next  = (step_reg == SW'(TRAIL_SEGMENTS - 1)) ? '0 : step_reg + 1'b1;
                    k_next     = '0;
                    ph_next    = 1'b0;
                    state_next = F_CALC;
                end
            end
            F_CALC:
            begin
                ph_next = ~ph_reg;
                if (ph_reg)
                begin
                    k_next = k_reg + 1'b1;
                    if (k_reg == 2'd2)
                        state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (rec_ready)
                    state_next = F_IDLE;
            end
            default:
                state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
            k_reg     <= '0;
            ph_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            k_reg     <= k_next;
            ph_reg    <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            base_reg[0] <= seg.base_x;
            base_reg[1] <= seg.base_y;
            base_reg[2] <= seg.base_z;
            tip_reg[0]  <= seg.tip_x;
            tip_reg[1]  <= seg.tip_y;
            tip_reg[2]  <= seg.tip_z;
            col_reg     <= seg.visible ? cfg.base_color : 32'h0;
            if (cfg.full_texture)
            begin
                uva_reg[0] <= u_tab[step_reg];
                uvb_reg[0] <= u_tab[step_reg];
                uva_reg[1] <= 16'h0;
                uvb_reg[1] <= 16'(Q_ONE);
            end
            else
            begin
                uva_reg[0] <= cfg.tex_u_edge_a;
                uvb_reg[0] <= cfg.tex_u_edge_b;
                uva_reg[1] <= cfg.tex_v_edge_a;
                uvb_reg[1] <= cfg.tex_v_edge_b;
            end
        end
        if (state_reg == F_CALC)
        begin
            if (ph_reg)
                eb_reg[k_reg] <= res;
            else
                ea_reg[k_reg] <= res;
        end
    end

endmodule

### src/crt_fifo.sv
// Two-entry queue of segment records between front and back.
module crt_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  crt_pkg::seg_rec_t wr_data,
    input  logic              wr_valid,
    output logic              wr_ready,
    output crt_pkg::seg_rec_t rd_data,
    output logic              rd_valid,
    input  logic              rd_ready
);
    import crt_pkg::*;

    localparam int DEPTH = 2;

    seg_rec_t   mem_reg [DEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = (cnt_reg != 2'(DEPTH));
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= ~wp_reg;
            if (rd)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

### src/crt_back.sv
// Back end: segment window and Catmull-Rom vertex generation with a reciprocal divider.
module crt_back #(
    parameter int SUBSTEPS = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  crt_pkg::seg_rec_t rec,
    input  logic              rec_valid,
    output logic              rec_ready,
    crt_vtx_if.source         vtx
);
    import crt_pkg::*;

    localparam int SSW   = (SUBSTEPS > 1) ? $clog2(SUBSTEPS) : 1;
    localparam int N3    = SUBSTEPS * SUBSTEPS * SUBSTEPS;
    localparam int D2    = 2 * N3;
    localparam int DW    = $clog2(D2);
    localparam int RW    = DW + 1;
    localparam int CH    = 12;
    localparam int NCH   = NW / CH;
    localparam int DCW   = $clog2(NCH);
    localparam int VW    = RW + CH;
    localparam int LSH   = DW + CH + DW;
    localparam int MW    = DW + CH + 2;
    localparam int PW    = VW + MW;
    localparam longint MREC = ((64'sd1 << LSH) + D2 - 1) / D2;
    localparam int LANES = 5;

    back_state_t        state_reg, state_next;
    logic [31:0]        pt_reg [WIN][2][3];
    logic [15:0]        uv_reg [WIN][2][2];
    logic [31:0]        col_reg [WIN];
    logic [2:0]         cnt_reg;
    logic               e_reg;
    logic [SSW-1:0]     s_reg;
    logic [9:0]         k1_reg, k2_reg, k3_reg;
    logic signed [NW-1:0] p1_reg [LANES];
    logic signed [NW-1:0] a_reg [LANES];
    logic signed [NW-1:0] b_reg [LANES];
    logic signed [NW-1:0] c_reg [LANES];
    logic signed [NW-1:0] t0_reg [LANES];
    logic signed [NW-1:0] t1_reg [LANES];
    logic signed [NW-1:0] t2_reg [LANES];
    logic signed [NW-1:0] t3_reg [LANES];
    logic [NW-1:0]      mag_reg [LANES];
    logic [RW-1:0]      rem_reg [LANES];
    logic               neg_reg [LANES];
    logic [DCW-1:0]     dc_reg;

    logic               ov_reg;
    logic [31:0]        o_pos_reg [3];
    logic [15:0]        o_uv_reg [2];
    logic [31:0]        o_col_reg;
    logic               o_e_reg;
    logic [1:0]         o_s_reg;
    logic               o_last_reg;

    logic signed [NW-1:0] pv [4][LANES];
    logic signed [NW-1:0] x [LANES];
    logic signed [NW-1:0] q [LANES];
    logic [VW-1:0]      vv [LANES];
    logic [PW-1:0]      prodq [LANES];
    logic [CH-1:0]      qd [LANES];
    logic [VW-1:0]      qm [LANES];
    logic               s_end, load_out;

    // long division by D2, 12 bits per step, each step by reciprocal multiplication
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            for (int l = 0; l < 3; l++)
                pv[j][l] = NW'($signed(pt_reg[j][e_reg][l]));
            for (int l = 0; l < 2; l++)
                pv[j][l + 3] = $signed({32'b0, uv_reg[j][e_reg][l]});
        end
        for (int l = 0; l < LANES; l++)
        begin
            x[l]     = t0_reg[l] + t1_reg[l] + t2_reg[l] + t3_reg[l] + NW'(N3);
            q[l]     = neg_reg[l] ? -$signed(mag_reg[l]) : $signed(mag_reg[l]);
            vv[l]    = {rem_reg[l], mag_reg[l][NW-1 -: CH]};
            prodq[l] = PW'(vv[l]) * PW'(MREC);
            qd[l]    = CH'(prodq[l] >> LSH);
            qm[l]    = VW'(qd[l]) * VW'(D2);
        end
    end

    assign s_end     = (s_reg == SSW'(SUBSTEPS - 1));
    assign rec_ready = (state_reg == B_IDLE);
    assign load_out  = (state_reg == B_OUT) && (!ov_reg || vtx.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (rec_valid && (cnt_reg >= 3'd3))
                    state_next = B_COEF;
            end
            B_COEF:  state_next = B_MUL;
            B_MUL:   state_next = B_SUM;
            B_SUM:   state_next = B_DIV;
            B_DIV:
            begin
                if (dc_reg == DCW'(NCH - 1))
                    state_next = B_OUT;
            end
            B_OUT:
            begin
                if (load_out)
                    state_next = (s_end && e_reg) ? B_IDLE : B_COEF;
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            cnt_reg   <= '0;
            e_reg     <= 1'b0;
            s_reg     <= '0;
            dc_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (rec_valid && rec_ready)
            begin
                if (cnt_reg < 3'(WIN))
                    cnt_reg <= cnt_reg + 1'b1;
                e_reg <= 1'b0;
                s_reg <= '0;
            end
            if (state_reg == B_SUM)
                dc_reg <= '0;
            else if (state_reg == B_DIV)
                dc_reg <= dc_reg + 1'b1;
            if (load_out)
            begin
                ov_reg <= 1'b1;
                if (s_end)
                begin
                    s_reg <= '0;
                    e_reg <= 1'b1;
                end
                else
                    s_reg <= s_reg + 1'b1;
            end
            else if (vtx.ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_valid && rec_ready)
        begin
            for (int j = 0; j < WIN - 1; j++)
            begin
                pt_reg[j]  <= pt_reg[j + 1];
                uv_reg[j]  <= uv_reg[j + 1];
                col_reg[j] <= col_reg[j + 1];
            end
            for (int k = 0; k < 3; k++)
            begin
                pt_reg[WIN - 1][0][k] <= rec.ea[k];
                pt_reg[WIN - 1][1][k] <= rec.eb[k];
            end
            for (int k = 0; k < 2; k++)
            begin
                uv_reg[WIN - 1][0][k] <= rec.uva[k];
                uv_reg[WIN - 1][1][k] <= rec.uvb[k];
            end
            col_reg[WIN - 1] <= rec.col;
        end
        case (state_reg)
            B_COEF:
            begin
                k1_reg <= 10'(s_reg * SUBSTEPS * SUBSTEPS);
                k2_reg <= 10'(s_reg * s_reg * SUBSTEPS);
                k3_reg <= 10'(s_reg * s_reg * s_reg);
                for (int l = 0; l < LANES; l++)
                begin
                    p1_reg[l] <= pv[1][l];
                    a_reg[l]  <= pv[2][l] - pv[0][l];
                    b_reg[l]  <= 2 * pv[0][l] - 5 * pv[1][l] + 4 * pv[2][l] - pv[3][l];
                    c_reg[l]  <= 3 * pv[1][l] - pv[0][l] - 3 * pv[2][l] + pv[3][l];
                end
            end
            B_MUL:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    t0_reg[l] <= p1_reg[l] * NW'(D2);
                    t1_reg[l] <= a_reg[l] * $signed({38'b0, k1_reg});
                    t2_reg[l] <= b_reg[l] * $signed({38'b0, k2_reg});
                    t3_reg[l] <= c_reg[l] * $signed({38'b0, k3_reg});
                end
            end
            B_SUM:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    neg_reg[l] <= x[l][NW-1];
                    mag_reg[l] <= x[l][NW-1] ? NW'(-x[l] + NW'(D2 - 1)) : x[l];
                    rem_reg[l] <= '0;
                end
            end
            B_DIV:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[l] <= RW'(vv[l] - qm[l]);
                    mag_reg[l] <= {mag_reg[l][NW-CH-1:0], qd[l]};
                end
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            for (int l = 0; l < 3; l++)
                o_pos_reg[l] <= sat_s32(q[l]);
            for (int l = 0; l < 2; l++)
                o_uv_reg[l] <= sat_u16(q[l + 3]);
            o_col_reg  <= col_reg[1];
            o_e_reg    <= e_reg;
            o_s_reg    <= 2'(s_reg);
            o_last_reg <= e_reg && s_end;
        end
    end

    assign vtx.valid        = ov_reg;
    assign vtx.pos_x        = o_pos_reg[0];
    assign vtx.pos_y        = o_pos_reg[1];
    assign vtx.pos_z        = o_pos_reg[2];
    assign vtx.tex_u        = o_uv_reg[0];
    assign vtx.tex_v        = o_uv_reg[1];
    assign vtx.vertex_color = o_col_reg;
    assign vtx.edge_res     = o_e_reg;
    assign vtx.substep      = o_s_reg;
    assign vtx.last         = o_last_reg;

endmodule

### src/trail_catmull_rom_tessellator.sv
// Top level: APB register bank, segment front end, queue and vertex back end.
// Vertices start once four segments are held in the back-end window.
// Back end: per vertex three setup states, four reciprocal divide steps and one output state;
// 2*SUBSTEPS vertices per segment, then back to idle to take the next record.
// Front end: per segment accept, edge-blend steps and a push; sink stalls hold the push.
// rst_n is asynchronous, active low; it empties window and queue, loads register defaults.
module trail_catmull_rom_tessellator #(
    parameter int TRAIL_SEGMENTS = 7,
    parameter int SUBSTEPS       = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    crt_seg_if.sink     seg,
    crt_vtx_if.source   vtx,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import crt_pkg::*;

    cfg_t     cfg_reg;
    seg_rec_t f_rec, q_rec;
    logic     f_valid, f_ready, q_valid, q_ready;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_width      <= 16'(Q_ONE);
            cfg_reg.highlight_width <= 16'h0;
            cfg_reg.base_color      <= 32'hFFFF_FFFF;
            cfg_reg.full_texture    <= 1'b0;
            cfg_reg.tex_u_edge_a    <= 16'h0;
            cfg_reg.tex_u_edge_b    <= 16'h0;
            cfg_reg.tex_v_edge_a    <= 16'h0;
            cfg_reg.tex_v_edge_b    <= 16'h0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[4:2])
                REG_LINE_WIDTH:      cfg_reg.line_width      <= pwdata[15:0];
                REG_HIGHLIGHT_WIDTH: cfg_reg.highlight_width <= pwdata[15:0];
                REG_BASE_COLOR:      cfg_reg.base_color      <= pwdata;
                REG_FULL_TEXTURE:    cfg_reg.full_texture    <= pwdata[0];
                REG_TEX_U_EDGE_A:    cfg_reg.tex_u_edge_a    <= pwdata[15:0];
                REG_TEX_U_EDGE_B:    cfg_reg.tex_u_edge_b    <= pwdata[15:0];
                REG_TEX_V_EDGE_A:    cfg_reg.tex_v_edge_a    <= pwdata[15:0];
                REG_TEX_V_EDGE_B:    cfg_reg.tex_v_edge_b    <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_LINE_WIDTH:      prdata = {16'h0, cfg_reg.line_width};
            REG_HIGHLIGHT_WIDTH: prdata = {16'h0, cfg_reg.highlight_width};
            REG_BASE_COLOR:      prdata = cfg_reg.base_color;
            REG_FULL_TEXTURE:    prdata = {31'h0, cfg_reg.full_texture};
            REG_TEX_U_EDGE_A:    prdata = {16'h0, cfg_reg.tex_u_edge_a};
            REG_TEX_U_EDGE_B:    prdata = {16'h0, cfg_reg.tex_u_edge_b};
            REG_TEX_V_EDGE_A:    prdata = {16'h0, cfg_reg.tex_v_edge_a};
            REG_TEX_V_EDGE_B:    prdata = {16'h0, cfg_reg.tex_v_edge_b};
            default:             prdata = 32'h0;
        endcase
    end

    crt_front #(
        .TRAIL_SEGMENTS (TRAIL_SEGMENTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg       (seg),
        .cfg       (cfg_reg),
        .rec       (f_rec),
        .rec_valid (f_valid),
        .rec_ready (f_ready)
    );

    crt_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (f_rec),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .rd_data  (q_rec),
        .rd_valid (q_valid),
        .rd_ready (q_ready)
    );

    crt_back #(
        .SUBSTEPS (SUBSTEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec       (q_rec),
        .rec_valid (q_valid),
        .rec_ready (q_ready),
        .vtx       (vtx)
    );

endmodule

### tb/trail_catmull_rom_tessellator_test.sv
// Testbench for the trail Catmull-Rom tessellator: directed table, random segments, vertex checks.
module trail_catmull_rom_tessellator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import crt_pkg::*;

    localparam int TRAIL_SEGMENTS = 7;
    localparam int SUBSTEPS = 3;
    localparam int VERTEX_LATENCY = 400;

    typedef struct {
        logic signed [31:0] px, py, pz;
        logic [15:0] u, v;
        logic [31:0] color;
        logic edge_sel;
        logic [1:0] step;
        logic lst;
    } vertex_t;

    typedef struct {
        logic signed [31:0] bx, by, bz, tx, ty, tz;
        logic vis;
        logic has_exp;
        logic signed [31:0] exp_x;
    } seg_row_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    crt_seg_if seg ();
    crt_vtx_if vtx ();

    trail_catmull_rom_tessellator dut (
        .clk(clk), .rst_n(rst_n), .seg(seg), .vtx(vtx),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [15:0] m_line_w, m_hl_w, m_ua, m_ub, m_va, m_vb;
    logic [31:0] m_color;
    logic m_full;
    longint win_pt[WIN][2][3];
    longint win_uv[WIN][2][2];
    logic [31:0] win_col[WIN];
    int seg_count, tex_step;

    vertex_t expected_vertices[$];
    int errors, vertex_count, seg_sent;
    bit random_sink;
    bit sink_busy;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic longint rnd_div(longint num, longint den);
        longint a, b;
        a = 2 * num + den;
        b = 2 * den;
        if (a >= 0)
            return a / b;
        return -((-a + b - 1) / b);
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint cr_point(longint p0, longint p1, longint p2, longint p3,
                                        longint s);
        longint a, b, c, n, num;
        n = SUBSTEPS;
        a = p2 - p0;
        b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c = -p0 + 3 * p1 - 3 * p2 + p3;
        num = 2 * p1 * n * n * n + a * s * n * n + b * s * s * n + c * s * s * s;
        return rnd_div(num, 2 * n * n * n);
    endfunction

    function automatic void model_reset();
        m_line_w = 16'd32768; m_hl_w = 16'd0; m_color = 32'hFFFF_FFFF; m_full = 1'b0;
        m_ua = 16'd0; m_ub = 16'd0; m_va = 16'd0; m_vb = 16'd0;
        for (int i = 0; i < WIN; i++)
        begin
            win_col[i] = 0;
            for (int e = 0; e < 2; e++)
            begin
                for (int k = 0; k < 3; k++) win_pt[i][e][k] = 0;
                for (int k = 0; k < 2; k++) win_uv[i][e][k] = 0;
            end
        end
        seg_count = 0;
        tex_step = 0;
    endfunction

    function automatic void model_write(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_LINE_WIDTH: m_line_w = val[15:0];
            REG_HIGHLIGHT_WIDTH: m_hl_w = val[15:0];
            REG_BASE_COLOR: m_color = val;
            REG_FULL_TEXTURE: m_full = val[0];
            REG_TEX_U_EDGE_A: m_ua = val[15:0];
            REG_TEX_U_EDGE_B: m_ub = val[15:0];
            REG_TEX_V_EDGE_A: m_va = val[15:0];
            default: m_vb = val[15:0];
        endcase
    endfunction

    function automatic void predict_vertices(seg_row_t r);
        longint wa, wb, p1, p2, a, b, u;
        longint ea[3], eb[3], uva[2], uvb[2];
        logic [31:0] col;
        vertex_t vx;
        wa = Q_ONE - ((m_hl_w > Q_ONE) ? Q_ONE : m_hl_w);
        wb = Q_ONE - ((m_line_w > Q_ONE) ? Q_ONE : m_line_w);
        for (int k = 0; k < 3; k++)
        begin
            p1 = (k == 0) ? r.bx : (k == 1) ? r.by : r.bz;
            p2 = (k == 0) ? r.tx : (k == 1) ? r.ty : r.tz;
            a = clip(p1 + rnd_div((p2 - p1) * wa, Q_ONE), -64'sd2147483648, 64'sd2147483647);
            b = clip(p1 + rnd_div((a - p1) * wb, Q_ONE), -64'sd2147483648, 64'sd2147483647);
            ea[k] = a;
            eb[k] = b;
        end
        col = r.vis ? m_color : 32'd0;
        if (m_full)
        begin
            u = clip(rnd_div(tex_step * Q_ONE, TRAIL_SEGMENTS - 1), 0, 65535);
            uva[0] = u; uvb[0] = u; uva[1] = 0; uvb[1] = Q_ONE;
        end
        else
        begin
            uva[0] = m_ua; uvb[0] = m_ub; uva[1] = m_va; uvb[1] = m_vb;
        end
        tex_step = (tex_step + 1) % TRAIL_SEGMENTS;
        for (int i = 0; i < WIN - 1; i++)
        begin
            win_pt[i] = win_pt[i + 1];
            win_uv[i] = win_uv[i + 1];
            win_col[i] = win_col[i + 1];
        end
        for (int k = 0; k < 3; k++)
        begin
            win_pt[WIN - 1][0][k] = ea[k];
            win_pt[WIN - 1][1][k] = eb[k];
        end
        for (int k = 0; k < 2; k++)
        begin
            win_uv[WIN - 1][0][k] = uva[k];
            win_uv[WIN - 1][1][k] = uvb[k];
        end
        win_col[WIN - 1] = col;
        if (seg_count < WIN)
            seg_count++;
        if (seg_count < WIN)
            return;
        for (int e = 0; e < 2; e++)
        begin
            for (int s = 0; s < SUBSTEPS; s++)
            begin
                longint c[5];
                for (int k = 0; k < 3; k++)
                    c[k] = clip(cr_point(win_pt[0][e][k], win_pt[1][e][k], win_pt[2][e][k],
                                         win_pt[3][e][k], s), -64'sd2147483648, 64'sd2147483647);
                for (int k = 0; k < 2; k++)
                    c[3 + k] = clip(cr_point(win_uv[0][e][k], win_uv[1][e][k],
                                             win_uv[2][e][k], win_uv[3][e][k], s), 0, 65535);
                vx.px = 32'(c[0]); vx.py = 32'(c[1]); vx.pz = 32'(c[2]);
                vx.u = 16'(c[3]); vx.v = 16'(c[4]);
                vx.color = win_col[1];
                vx.edge_sel = 1'(e);
                vx.step = 2'(s);
                vx.lst = (e == 1 && s == SUBSTEPS - 1);
                expected_vertices.push_back(vx);
            end
        end
    endfunction

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        model_write(idx, val);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_vertices.size() != 0) @(posedge clk);
        repeat (VERTEX_LATENCY) @(posedge clk);
    endtask

    task automatic send_segment(seg_row_t r, bit gaps);
        if (gaps && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(20, 400) : $urandom_range(1, 3))
                @(posedge clk);
        seg.valid <= 1;
        seg.base_x <= r.bx; seg.base_y <= r.by; seg.base_z <= r.bz;
        seg.tip_x <= r.tx; seg.tip_y <= r.ty; seg.tip_z <= r.tz;
        seg.visible <= r.vis;
        @(posedge clk);
        while (!seg.ready) @(posedge clk);
        predict_vertices(r);
        seg_sent++;
        seg.valid <= 0;
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed($urandom_range(0, 65536 * 8)) - 32'sd262144;
            default: return $urandom;
        endcase
    endfunction

    function automatic seg_row_t rand_row();
        seg_row_t r;
        r.bx = rand_coord(); r.by = rand_coord(); r.bz = rand_coord();
        r.tx = rand_coord(); r.ty = rand_coord(); r.tz = rand_coord();
        r.vis = 1'($urandom_range(0, 1));
        r.has_exp = 0;
        r.exp_x = 0;
        return r;
    endfunction

    function automatic logic [31:0] rand_width();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return 32'd32768;
            2: return 32'($urandom_range(32769, 65535));
            default: return 32'($urandom_range(0, 32768));
        endcase
    endfunction

    // vertex sink: random stalls when random_sink is set, checked against the oldest expectation
    always @(posedge clk)
    begin
        vertex_t ex;
        if (rst_n)
        begin
            if (vtx.valid && vtx.ready)
            begin
                vertex_count++;
                if (expected_vertices.size() == 0)
                begin
                    errors++;
                    $display("%0t: vertex with nothing expected, got x=%h", $realtime, vtx.pos_x);
                end
                else
                begin
                    ex = expected_vertices.pop_front();
                    if (vtx.pos_x !== ex.px || vtx.pos_y !== ex.py || vtx.pos_z !== ex.pz ||
                        vtx.tex_u !== ex.u || vtx.tex_v !== ex.v ||
                        vtx.vertex_color !== ex.color || vtx.edge_res !== ex.edge_sel ||
                        vtx.substep !== ex.step || vtx.last !== ex.lst)
                    begin
                        errors++;
                        $display("%0t: vertex mismatch expected %h %h %h u%h v%h c%h e%b s%0d l%b",
                                 $realtime, ex.px, ex.py, ex.pz, ex.u, ex.v, ex.color,
                                 ex.edge_sel, ex.step, ex.lst);
                        $display("%0t:                 actual %h %h %h u%h v%h c%h e%b s%0d l%b",
                                 $realtime, vtx.pos_x, vtx.pos_y, vtx.pos_z, vtx.tex_u,
                                 vtx.tex_v, vtx.vertex_color, vtx.edge_res, vtx.substep,
                                 vtx.last);
                    end
                end
            end
            if (!random_sink)
                vtx.ready <= 1;
            else if (sink_busy)
            begin
                if ($urandom_range(0, 7) == 0) begin vtx.ready <= 1; sink_busy = 0; end
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                vtx.ready <= 0;
                sink_busy = ($urandom_range(0, 9) == 0);
            end
            else
                vtx.ready <= 1;
        end
    end

    seg_row_t directed[] = '{
        '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 1, 0, 0},
        '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000, 0, 0, 0},
        '{32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000, 0, 0, 1, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 1, 0},
        '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
          32'sh7FFF_FFFF, 1, 0, 0},
        '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
          32'sh8000_0000, 1, 0, 0},
        '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
          32'sh7FFF_FFFF, 0, 0, 0},
        '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
          32'sh7FFF_FFFF, 1, 1, 32'sh8000_0000},
        '{32'sh0000_0001, 32'shFFFF_FFFF, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_8000,
          32'shFFFF_8000, 1, 0, 0},
        '{32'sh1234_5678, 32'shEDCB_A987, 32'sh0F0F_0F0F, 32'shF0F0_F0F0, 3, -3, 0, 0, 0}
    };

    initial
    begin
        vertex_t first;
        rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        seg.valid = 0; seg.base_x = 0; seg.base_y = 0; seg.base_z = 0;
        seg.tip_x = 0; seg.tip_y = 0; seg.tip_z = 0; seg.visible = 0;
        vtx.ready = 1;
        random_sink = 0; sink_busy = 0;
        errors = 0; vertex_count = 0; seg_sent = 0;
        model_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset registers first, table rows with an x value typed in
        foreach (directed[i])
        begin
            send_segment(directed[i], 0);
            if (directed[i].has_exp)
            begin
                first = expected_vertices[expected_vertices.size() - 2 * SUBSTEPS];
                if (first.px !== directed[i].exp_x)
                begin
                    errors++;
                    $display("%0t: table row %0d expected x %h, predicted %h", $realtime, i,
                             directed[i].exp_x, first.px);
                end
            end
        end
        wait_drained();

        // register extremes, full texture, fixed UV at extremes
        reg_write(REG_LINE_WIDTH, 32'd0);
        reg_write(REG_HIGHLIGHT_WIDTH, 32'd32768);
        reg_write(REG_FULL_TEXTURE, 32'd1);
        reg_write(REG_BASE_COLOR, 32'h0000_0000);
        for (int i = 0; i < 8; i++) send_segment(rand_row(), 0);
        wait_drained();
        reg_write(REG_LINE_WIDTH, 32'd65535);
        reg_write(REG_HIGHLIGHT_WIDTH, 32'd65535);
        reg_write(REG_FULL_TEXTURE, 32'd0);
        reg_write(REG_BASE_COLOR, 32'hA5C3_0F96);
        reg_write(REG_TEX_U_EDGE_A, 32'd65535);
        reg_write(REG_TEX_U_EDGE_B, 32'd0);
        reg_write(REG_TEX_V_EDGE_A, 32'd0);
        reg_write(REG_TEX_V_EDGE_B, 32'd65535);
        for (int i = 0; i < 8; i++) send_segment(rand_row(), 0);
        wait_drained();

        // random phases, fresh settings each time
        random_sink = 1;
        for (int ph = 0; ph < 12; ph++)
        begin
            reg_write(REG_LINE_WIDTH, rand_width());
            reg_write(REG_HIGHLIGHT_WIDTH, rand_width());
            reg_write(REG_BASE_COLOR, $urandom);
            reg_write(REG_FULL_TEXTURE, $urandom_range(0, 1));
            reg_write(REG_TEX_U_EDGE_A, $urandom_range(0, 65535));
            reg_write(REG_TEX_U_EDGE_B, $urandom_range(0, 65535));
            reg_write(REG_TEX_V_EDGE_A, $urandom_range(0, 65535));
            reg_write(REG_TEX_V_EDGE_B, $urandom_range(0, 65535));
            for (int i = 0; i < 38; i++)
            begin
                send_segment(rand_row(), 1);
                if (i == 20)
                    while (expected_vertices.size() != 0) @(posedge clk);
            end
            wait_drained();
        end

        $display("Sent %0d segments over 15 register settings; checked %0d vertices.",
                 seg_sent, vertex_count);
        if (errors == 0 && expected_vertices.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
